/* rtl/adam_upd_pkg.sv */
// Shared widths, register codes and operand bundles for the Adam update engine.
`timescale 1ns / 1ps

package adam_upd_pkg;

    // Field widths.
    localparam int ADDR_W    = 10;
    localparam int DATA_W    = 32;
    localparam int LR_W      = 24;
    localparam int BETA_W    = 16;
    localparam int EPS_W     = 32;
    localparam int POW_W     = 33;
    localparam int MOM2_W    = 64;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B1  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B2  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS = 2'd3;

    localparam logic [LR_W-1:0]   LR_RESET  = 24'd16777;
    localparam logic [BETA_W-1:0] B1_RESET  = 16'd58982;
    localparam logic [BETA_W-1:0] B2_RESET  = 16'd65470;
    localparam logic [EPS_W-1:0]  EPS_RESET = 32'd43;

    // 1.0 in unsigned Q1.32.
    localparam logic [POW_W-1:0] POW_ONE = 33'h1_0000_0000;

    localparam logic [DATA_W-1:0] PARAM_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] PARAM_MIN = 32'h8000_0000;

    // Serial multiply-accumulate unit.
    localparam int ACC_W = 89;
    localparam int OPA_W = 65;
    localparam int MUL_W = 32;
    localparam int CNT_W = 6;

    // Serial divider.
    localparam int QUO_W  = 64;
    localparam int DEN_W  = 49;
    localparam int DCNT_W = 7;

    typedef struct packed {
        logic signed [OPA_W-1:0] a;
        logic signed [OPA_W-1:0] b;
        logic [MUL_W-1:0]        x;
        logic [MUL_W-1:0]        y;
        logic [CNT_W-1:0]        len;
    } t_mac_op;

    typedef struct packed {
        logic [QUO_W-1:0] hi;
        logic [QUO_W-1:0] lo;
        logic [DEN_W-1:0] den;
    } t_div_op;

endpackage

/* rtl/adam_optimizer_update.sv */
// Top level of the Adam update engine: sequencer, moment stores and output register.
`timescale 1ns / 1ps

// Adam update engine in fixed point. Each input transfer names one element of
// a flat store of ELEMENT_COUNT entries and brings its gradient and current
// parameter; the engine updates the element's first and second moments,
// applies bias correction and returns one output transfer with the new,
// saturated parameter. When an item starts a pass, the two decay powers are
// updated first. Each item uses three 64-step divisions on the shared
// radix-2 divider, the bit-serial multiply-accumulate unit and the 32-step
// square root; a division that saturates finishes early. After reset the
// engine clears both moment stores, one entry per cycle, before it takes the
// first item; configuration writes are taken at any time and must only be
// issued while the engine is idle. A finished result waits in an output
// register, so the next item can be accepted while it is still pending.

module adam_optimizer_update #(
    parameter int ELEMENT_COUNT = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,

    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic [adam_upd_pkg::ADDR_W-1:0]          i_element_address,
    input  logic signed [adam_upd_pkg::DATA_W-1:0]   i_gradient,
    input  logic signed [adam_upd_pkg::DATA_W-1:0]   i_param_value,
    input  logic                                     i_new_pass,

    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic [adam_upd_pkg::ADDR_W-1:0]          o_address_out,
    output logic signed [adam_upd_pkg::DATA_W-1:0]   o_updated_param,
    output logic                                     o_saturated,

    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [adam_upd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [adam_upd_pkg::DATA_W-1:0]          i_cfg_data
);
    import adam_upd_pkg::*;

    localparam int IDX_W = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
    localparam logic [IDX_W:0]   MOD_N    = (IDX_W+1)'(ELEMENT_COUNT);
    localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(ELEMENT_COUNT - 1);

    // Sequencer states.
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_PW1   = 4'd4;
    localparam logic [3:0] S_PW2   = 4'd5;
    localparam logic [3:0] S_M     = 4'd6;
    localparam logic [3:0] S_G2    = 4'd7;
    localparam logic [3:0] S_V     = 4'd8;
    localparam logic [3:0] S_MH    = 4'd9;
    localparam logic [3:0] S_NUM   = 4'd10;
    localparam logic [3:0] S_VH    = 4'd11;
    localparam logic [3:0] S_SQ    = 4'd12;
    localparam logic [3:0] S_ST    = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;

    // Configuration registers.
    logic [LR_W-1:0]   r_lr;
    logic [BETA_W-1:0] r_b1;
    logic [BETA_W-1:0] r_b2;
    logic [EPS_W-1:0]  r_eps;

    // Running powers of the two decay factors, unsigned Q1.32.
    logic [POW_W-1:0]  r_bp1;
    logic [POW_W-1:0]  r_bp2;

    // Control.
    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic              r_go;
    logic              n_go;
    logic [IDX_W-1:0]  r_clr;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;

    // Item payload and intermediate results.
    logic [ADDR_W-1:0]        r_addr;
    logic signed [DATA_W-1:0] r_g;
    logic signed [DATA_W-1:0] r_p;
    logic                     r_new_pass;
    logic [ADDR_W-1:0]        r_mod_a;
    logic [IDX_W-1:0]         r_idx;
    logic [DATA_W-1:0]        r_m;
    logic                     r_neg;
    logic [MOM2_W-1:0]        r_g2;
    logic [MOM2_W-1:0]        r_v;
    logic [MOM2_W-1:0]        r_sq_x;
    logic [33:0]              r_sq_rem;
    logic [31:0]              r_root;
    logic [POW_W-1:0]         r_step;

    logic [ADDR_W-1:0]        r_out_addr;
    logic [DATA_W-1:0]        r_out_param;
    logic                     r_out_sat;

    // Moment stores with registered reads.
    logic [DATA_W-1:0] r_first_moment  [ELEMENT_COUNT];
    logic [MOM2_W-1:0] r_second_moment [ELEMENT_COUNT];
    logic [DATA_W-1:0] r_rd_m;
    logic [MOM2_W-1:0] r_rd_v;

    // Arithmetic units.
    t_mac_op                 mac_op;
    logic                    mac_start;
    logic                    mac_done;
    logic signed [ACC_W-1:0] mac_acc;
    logic [ACC_W-1:0]        mac_rnd;
    t_div_op                 div_op;
    logic                    div_start;
    logic                    div_done;
    logic [QUO_W-1:0]        div_quo;

    logic [16:0]        c1;
    logic [16:0]        c2;
    logic [DATA_W-1:0]  g_abs;
    logic [DATA_W-1:0]  m_abs;
    logic [DATA_W-1:0]  m_new;
    logic [POW_W-1:0]   bp_new;
    logic [MOM2_W-1:0]  v_new;
    logic [POW_W-1:0]   bc1;
    logic [POW_W-1:0]   bc2;
    logic [DEN_W-1:0]   den_sum;
    logic [DEN_W-1:0]   step_den;

    logic [IDX_W:0]     mod_t;
    logic [IDX_W-1:0]   n_idx;
    logic [35:0]        sq_t;
    logic [35:0]        sq_trial;
    logic               sq_ge;
    logic [33:0]        n_sq_rem;

    logic [34:0]        res;
    logic               res_sat;
    logic [DATA_W-1:0]  res_param;
    logic               out_load;

    logic [IDX_W-1:0]   mem_addr;
    logic               we_m;
    logic               we_v;
    logic [DATA_W-1:0]  wd_m;
    logic [MOM2_W-1:0]  wd_v;

    // ------------------------------------------------------------------
    // Configuration port. Writes are always taken.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr  <= LR_RESET;
            r_b1  <= B1_RESET;
            r_b2  <= B2_RESET;
            r_eps <= EPS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LR:  r_lr  <= i_cfg_data[LR_W-1:0];
                CFG_B1:  r_b1  <= i_cfg_data[BETA_W-1:0];
                CFG_B2:  r_b2  <= i_cfg_data[BETA_W-1:0];
                CFG_EPS: r_eps <= i_cfg_data[EPS_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Derived values.
    // ------------------------------------------------------------------
    always_comb begin
        c1      = 17'h1_0000 - {1'b0, r_b1};
        c2      = 17'h1_0000 - {1'b0, r_b2};
        g_abs   = r_g[DATA_W-1] ? DATA_W'(-r_g) : r_g;
        m_abs   = r_neg ? DATA_W'(-r_m) : r_m;

        // The moment and power product sums are rounded to nearest before they drop 16 bits.
        mac_rnd = mac_acc + ACC_W'(32768);
        m_new   = mac_rnd[47:16];
        bp_new  = mac_rnd[48:16];
        v_new   = mac_rnd[79:16];

        // Bias correction 1 - beta^t; while the power is still 1.0 the moment
        // is used as it is, which a correction of 1.0 gives.
        bc1 = POW_ONE - ((r_bp1 > POW_ONE) ? POW_ONE : r_bp1);
        bc2 = POW_ONE - ((r_bp2 > POW_ONE) ? POW_ONE : r_bp2);
        if (bc1 == '0) begin
            bc1 = POW_ONE;
        end
        if (bc2 == '0) begin
            bc2 = POW_ONE;
        end

        // The root widened to Q16.32 plus epsilon; a zero denominator becomes one LSB.
        den_sum  = {1'b0, r_root, 16'b0} + {{(DEN_W-EPS_W){1'b0}}, r_eps};
        step_den = (den_sum == '0) ? DEN_W'(1) : den_sum;
    end

    // ------------------------------------------------------------------
    // Store index: the address modulo ELEMENT_COUNT, one address bit per cycle.
    // ------------------------------------------------------------------
    always_comb begin
        mod_t = {r_idx, r_mod_a[ADDR_W-1]};
        n_idx = (mod_t >= MOD_N) ? IDX_W'(mod_t - MOD_N) : mod_t[IDX_W-1:0];
    end

    // ------------------------------------------------------------------
    // Square root, two radicand bits per cycle.
    // ------------------------------------------------------------------
    always_comb begin
        sq_t     = {r_sq_rem, r_sq_x[MOM2_W-1:MOM2_W-2]};
        sq_trial = {2'b00, r_root, 2'b01};
        sq_ge    = (sq_t >= sq_trial);
        n_sq_rem = sq_ge ? 34'(sq_t - sq_trial) : sq_t[33:0];
    end

    // ------------------------------------------------------------------
    // Operand selection for the shared units.
    // ------------------------------------------------------------------
    always_comb begin
        mac_op = '0;
        unique case (r_state)
            S_PW1: begin
                mac_op.a   = {32'b0, r_bp1};
                mac_op.x   = {r_b1, 16'b0};
                mac_op.len = CNT_W'(BETA_W);
            end
            S_PW2: begin
                mac_op.a   = {32'b0, r_bp2};
                mac_op.x   = {r_b2, 16'b0};
                mac_op.len = CNT_W'(BETA_W);
            end
            S_M: begin
                mac_op.a   = {{33{r_rd_m[DATA_W-1]}}, r_rd_m};
                mac_op.b   = {{33{r_g[DATA_W-1]}}, r_g};
                mac_op.x   = {1'b0, r_b1, 15'b0};
                mac_op.y   = {c1, 15'b0};
                mac_op.len = CNT_W'(17);
            end
            S_G2: begin
                mac_op.a   = {33'b0, g_abs};
                mac_op.x   = g_abs;
                mac_op.len = CNT_W'(MUL_W);
            end
            S_V: begin
                mac_op.a   = {1'b0, r_rd_v};
                mac_op.b   = {1'b0, r_g2};
                mac_op.x   = {1'b0, r_b2, 15'b0};
                mac_op.y   = {c2, 15'b0};
                mac_op.len = CNT_W'(17);
            end
            S_NUM: begin
                // The divider still holds the corrected first moment.
                mac_op.a   = {1'b0, div_quo};
                mac_op.x   = {r_lr, 8'b0};
                mac_op.len = CNT_W'(LR_W);
            end
            default: begin
                mac_op = '0;
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_MH: begin
                div_op.hi  = '0;
                div_op.lo  = {m_abs, 32'b0};
                div_op.den = {{(DEN_W-POW_W){1'b0}}, bc1};
            end
            S_VH: begin
                div_op.hi  = {32'b0, r_v[63:32]};
                div_op.lo  = {r_v[31:0], 32'b0};
                div_op.den = {{(DEN_W-POW_W){1'b0}}, bc2};
            end
            default: begin
                // Step: learning rate times corrected moment times 2^8.
                div_op.hi  = {32'b0, mac_acc[87:56]};
                div_op.lo  = {mac_acc[55:0], 8'b0};
                div_op.den = step_den;
            end
        endcase
    end

    assign mac_start = r_go && (r_state == S_PW1 || r_state == S_PW2 || r_state == S_M ||
                                r_state == S_G2 || r_state == S_V || r_state == S_NUM);
    assign div_start = r_go && (r_state == S_MH || r_state == S_VH || r_state == S_ST);

    adam_upd_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mac_start),
        .i_op    (mac_op),
        .o_done  (mac_done),
        .o_acc   (mac_acc)
    );

    adam_upd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_op    (div_op),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign out_load   = (r_state == S_FIN) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_go    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_go    = 1'b1;
                n_state = r_new_pass ? S_PW1 : S_M;
            end
            S_PW1: begin
                if (mac_done) begin
                    n_go    = 1'b1;
                    n_state = S_PW2;
                end
            end
            S_PW2: begin
                if (mac_done) begin
                    n_go    = 1'b1;
                    n_state = S_M;
                end
            end
            S_M: begin
                if (mac_done) begin
                    n_go    = 1'b1;
                    n_state = S_G2;
                end
            end
            S_G2: begin
                if (mac_done) begin
                    n_go    = 1'b1;
                    n_state = S_V;
                end
            end
            S_V: begin
                if (mac_done) begin
                    n_go    = 1'b1;
                    n_state = S_MH;
                end
            end
            S_MH: begin
                if (div_done) begin
                    n_go    = 1'b1;
                    n_state = S_NUM;
                end
            end
            S_NUM: begin
                if (mac_done) begin
                    n_go    = 1'b1;
                    n_state = S_VH;
                end
            end
            S_VH: begin
                if (div_done) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_go    = 1'b1;
                    n_state = S_ST;
                end
            end
            S_ST: begin
                if (div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_go    <= 1'b0;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_bp1   <= POW_ONE;
            r_bp2   <= POW_ONE;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (r_state == S_IDLE && i_in_valid) begin
                r_cnt <= CNT_W'(ADDR_W);
            end else if (r_state == S_VH && div_done) begin
                r_cnt <= CNT_W'(32);
            end else if (r_state == S_MOD || r_state == S_SQ) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            // A new pass decays both powers before the element is worked on.
            if (r_state == S_PW1 && mac_done) begin
                r_bp1 <= bp_new;
            end
            if (r_state == S_PW2 && mac_done) begin
                r_bp2 <= bp_new;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_addr     <= i_element_address;
            r_g        <= i_gradient;
            r_p        <= i_param_value;
            r_new_pass <= i_new_pass;
            r_mod_a    <= i_element_address;
            r_idx      <= '0;
        end
        if (r_state == S_MOD) begin
            r_mod_a <= r_mod_a << 1;
            r_idx   <= n_idx;
        end
        if (r_state == S_M && mac_done) begin
            r_m   <= m_new;
            r_neg <= m_new[DATA_W-1];
        end
        if (r_state == S_G2 && mac_done) begin
            r_g2 <= mac_acc[MOM2_W-1:0];
        end
        if (r_state == S_V && mac_done) begin
            r_v <= v_new;
        end
        if (r_state == S_VH && div_done) begin
            r_sq_x   <= div_quo;
            r_sq_rem <= '0;
            r_root   <= '0;
        end
        if (r_state == S_SQ) begin
            r_sq_x   <= r_sq_x << 2;
            r_sq_rem <= n_sq_rem;
            r_root   <= {r_root[30:0], sq_ge};
        end
        if (r_state == S_ST && div_done) begin
            // The step is capped at 2^32 LSBs, 65536.0 in Q16.16 terms, before it is applied.
            r_step <= (div_quo > {31'b0, POW_ONE}) ? POW_ONE : div_quo[POW_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Moment stores. The clearing pass uses the same write port.
    // ------------------------------------------------------------------
    always_comb begin
        mem_addr = (r_state == S_CLEAR) ? r_clr : r_idx;
        we_m     = (r_state == S_CLEAR) || (r_state == S_M && mac_done);
        we_v     = (r_state == S_CLEAR) || (r_state == S_V && mac_done);
        wd_m     = (r_state == S_CLEAR) ? '0 : m_new;
        wd_v     = (r_state == S_CLEAR) ? '0 : v_new;
    end

    always_ff @(posedge i_clk) begin
        if (we_m) begin
            r_first_moment[mem_addr] <= wd_m;
        end
        r_rd_m <= r_first_moment[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (we_v) begin
            r_second_moment[mem_addr] <= wd_v;
        end
        r_rd_v <= r_second_moment[r_idx];
    end

    // ------------------------------------------------------------------
    // Parameter update and output register.
    // ------------------------------------------------------------------
    always_comb begin
        res = r_neg ? ({{3{r_p[DATA_W-1]}}, r_p} + {2'b00, r_step})
                    : ({{3{r_p[DATA_W-1]}}, r_p} - {2'b00, r_step});
        res_sat = (res[34:31] != 4'b0000) && (res[34:31] != 4'b1111);
        if (res_sat) begin
            res_param = res[34] ? PARAM_MIN : PARAM_MAX;
        end else begin
            res_param = res[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_addr  <= r_addr;
            r_out_param <= res_param;
            r_out_sat   <= res_sat;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_address_out   = r_out_addr;
    assign o_updated_param = r_out_param;
    assign o_saturated     = r_out_sat;

`ifndef SYNTHESIS
    // One item at a time: the input closes right after a transfer.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while an item is in progress");

    // The decay powers never rise above 1.0.
    a_pow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bp1 <= POW_ONE) && (r_bp2 <= POW_ONE))
        else $error("decay power above 1.0");

    // A new result only comes from the final state.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIN))
        else $error("result appeared outside the final state");

    // A clamped result sits at one end of the range.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_updated_param == PARAM_MAX || o_updated_param == PARAM_MIN))
        else $error("saturated flag with an unclamped value");

    // The multiplier only finishes in a state that waits for it.
    a_mac_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> (r_state == S_PW1 || r_state == S_PW2 || r_state == S_M ||
                      r_state == S_G2 || r_state == S_V || r_state == S_NUM))
        else $error("multiplier finished with no state waiting");
`endif

endmodule

/* rtl/adam_upd_mac.sv */
// Bit-serial multiply-accumulate unit: acc = a*x + b*y, one multiplier bit per cycle.
`timescale 1ns / 1ps

module adam_upd_mac (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  adam_upd_pkg::t_mac_op                   i_op,
    output logic                                    o_done,
    output logic signed [adam_upd_pkg::ACC_W-1:0]   o_acc
);
    import adam_upd_pkg::*;

    logic signed [OPA_W-1:0] r_a;
    logic signed [OPA_W-1:0] r_b;
    logic [MUL_W-1:0]        r_x;
    logic [MUL_W-1:0]        r_y;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_busy;
    logic                    r_done;
    logic signed [ACC_W-1:0] r_acc;

    logic signed [OPA_W-1:0] sel_a;
    logic signed [OPA_W-1:0] sel_b;
    logic signed [ACC_W-1:0] n_acc;

    // The multipliers are scanned from their top bit, so the sum doubles each step.
    always_comb begin
        sel_a = r_x[MUL_W-1] ? r_a : '0;
        sel_b = r_y[MUL_W-1] ? r_b : '0;
        n_acc = (r_acc <<< 1) + ACC_W'(sel_a) + ACC_W'(sel_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_op.len;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_op.a;
            r_b   <= i_op.b;
            r_x   <= i_op.x;
            r_y   <= i_op.y;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_x   <= r_x << 1;
            r_y   <= r_y << 1;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

/* rtl/adam_upd_div.sv */
// Restoring divider of a 128-bit dividend, one quotient bit per cycle, saturating.
`timescale 1ns / 1ps

module adam_upd_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  adam_upd_pkg::t_div_op             i_op,
    output logic                              o_done,
    output logic [adam_upd_pkg::QUO_W-1:0]    o_quo
);
    import adam_upd_pkg::*;

    logic [DEN_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_lo;
    logic [DEN_W-1:0]  r_den;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic [DEN_W-1:0]  n_rem;
    logic              ovf;

    always_comb begin
        trial = {r_rem, r_lo[QUO_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        // A high half at or above the divisor would give more than 64 quotient bits.
        ovf   = (i_op.hi >= {{(QUO_W-DEN_W){1'b0}}, i_op.den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= (i_start && ovf) || (r_busy && (r_cnt == DCNT_W'(1)));
            if (i_start) begin
                r_busy <= !ovf;
                r_cnt  <= DCNT_W'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Quotient bits shift in where dividend bits shift out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_op.den;
            r_rem <= i_op.hi[DEN_W-1:0];
            r_lo  <= ovf ? '1 : i_op.lo;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_lo  <= {r_lo[QUO_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_lo;

endmodule
